// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// File: rtl/core/bstk_pkg.sv
// ----------------------------------------------------------------------------
// bstk_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bstk_pkg;

  localparam int SCORE_W     = 32;
  localparam int TAG_W       = 16;
  localparam int POS_W       = 4;
  localparam int CMD_W       = 2;
  localparam int SEL_W       = 2;
  localparam int CNT_OUT_W   = 5;
  localparam int ENTRY_W     = SCORE_W + TAG_W;
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = CMD_W + SEL_W;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CMD_W-1:0] CMD_ASK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INS  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LARGER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd1;

  localparam logic                  LARGER_RST = 1'b1;
  localparam logic [CFG_DATA_W-1:0] LIMIT_RST  = 5'd10;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic set_q;
    logic at_hit;
    logic at_end;
    logic place;
    logic sh_rd;
    logic sh_wr;
    logic ins_wr;
    logic rd_issue;
    logic rd_cap;
    logic out_load;
  } bstk_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic sel_ok;
    logic n_lt_lim;
    logic n_zero;
    logic pos_lt_n;
    logic hit;
    logic scan_last;
    logic at_lt_nn;
    logic hi_eq_at;
    logic shift_last;
    logic out_free;
  } bstk_sts_t;

endpackage

// File: rtl/core/bounded_sorted_topk_list.sv
// ----------------------------------------------------------------------------
// bounded_sorted_topk_list
// Ranked top-k lists of (score, tag) with ask / insert / read requests.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/tready    | tuser {list_sel, cmd}; tdata {pos, tag, score}
//  out_    | out | out_tvalid/tready   | tdata {count, tag, score, entry_valid, qualifies}
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request at a time; entries sit in a single RAM with one read and one
// write port. Read: RAM read, capture, result. Ask: result straight away when
// the list is not full, else after a scan if the list is not empty. Insert:
// scan unless the list is empty, a read and a write per entry shifted down,
// then the entry write. Output is registered, so a new request is taken while a
// result waits. Reset (rst_n, synchronous) clears counts, config, result valid, scan flag and controller state.
// ----------------------------------------------------------------------------
module bounded_sorted_topk_list #(
  parameter int LIST_DEPTH = 16,
  parameter int NUM_LISTS  = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] score, [47:32] tag, [51:48] position, [55:52] zero
  input  logic [bstk_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] cmd, [3:2] list_sel
  input  logic [bstk_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] qualifies, [1] entry_valid, [33:2] entry_score, [49:34] entry_tag,
  // [54:50] entry_count, [55] zero
  output logic [bstk_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bstk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bstk_pkg::CFG_DATA_W-1:0]   cfg_data
);

  bstk_pkg::bstk_cmd_t cmd;
  bstk_pkg::bstk_sts_t sts;

  assign cfg_ready = 1'b1;

  bstk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bstk_dp #(
    .LIST_DEPTH (LIST_DEPTH),
    .NUM_LISTS  (NUM_LISTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

// File: rtl/core/bstk_ram.sv
// ----------------------------------------------------------------------------
// bstk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bstk_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 48,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/bstk_dp.sv
// ----------------------------------------------------------------------------
// bstk_dp
// Datapath: request capture, list counts, entry RAM, scan compare, result reg.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bstk_dp #(
  parameter int LIST_DEPTH = 16,
  parameter int NUM_LISTS  = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bstk_pkg::bstk_cmd_t                  cmd,
  output bstk_pkg::bstk_sts_t                  sts,
  input  logic [bstk_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [bstk_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bstk_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  input  logic [bstk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bstk_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DEPTH = NUM_LISTS * LIST_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int CW    = ($clog2(LIST_DEPTH + 2) > 5) ? $clog2(LIST_DEPTH + 2) : 5;

  // request
  logic [bstk_pkg::CMD_W-1:0]   cmd_r;
  logic [bstk_pkg::SEL_W-1:0]   sel_r;
  logic [bstk_pkg::SCORE_W-1:0] score_r;
  logic [bstk_pkg::TAG_W-1:0]   tag_r;
  logic [bstk_pkg::POS_W-1:0]   pos_r;

  // config
  logic                             larger_r;
  logic [bstk_pkg::CFG_DATA_W-1:0]  limit_r;

  // list state and sequencing
  logic [CW-1:0] cnt_r [NUM_LISTS];
  logic [CW-1:0] at_r;
  logic [CW-1:0] rd_idx_r;
  logic [CW-1:0] chk_r;
  logic [CW-1:0] sh_idx_r;
  logic          dv_r;

  // result
  logic                         q_r;
  logic                         ev_r;
  logic [bstk_pkg::SCORE_W-1:0] es_r;
  logic [bstk_pkg::TAG_W-1:0]   et_r;
  logic                         out_valid_r;
  logic [bstk_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic          sel_ok;
  logic [LW-1:0] sel_ix;
  logic [CW-1:0] n;
  logic [CW-1:0] lim;
  logic [CW-1:0] n_inc;
  logic [CW-1:0] nn;
  logic [AW-1:0] base_a;
  logic          scan_rd;
  logic          beats;

  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [bstk_pkg::ENTRY_W-1:0]     ram_wdata;
  logic                             ram_re;
  logic [AW-1:0]                    ram_raddr;
  logic [bstk_pkg::ENTRY_W-1:0]     ram_rdata;
  logic signed [bstk_pkg::SCORE_W-1:0] mem_score;
  logic signed [bstk_pkg::SCORE_W-1:0] req_score;

  assign sel_ok = 32'(sel_r) < NUM_LISTS;
  assign sel_ix = LW'(sel_r);
  assign n      = sel_ok ? cnt_r[sel_ix] : '0;
  assign lim    = (32'(limit_r) < LIST_DEPTH) ? CW'(limit_r) : CW'(LIST_DEPTH);
  assign n_inc  = n + 1'b1;
  assign nn     = (n_inc < lim) ? n_inc : lim;
  assign base_a = AW'(LIST_DEPTH * 32'(sel_ix));

  assign mem_score = ram_rdata[bstk_pkg::ENTRY_W-1:bstk_pkg::TAG_W];
  assign req_score = score_r;
  assign beats     = larger_r ? (req_score > mem_score) : (req_score < mem_score);
  assign scan_rd   = cmd.scan_step && (rd_idx_r < n);

  always_comb begin
    sts.cmd        = cmd_r;
    sts.sel_ok     = sel_ok;
    sts.n_lt_lim   = n < lim;
    sts.n_zero     = n == '0;
    sts.pos_lt_n   = CW'(pos_r) < n;
    sts.hit        = dv_r && beats;
    sts.scan_last  = dv_r && (chk_r == n - 1'b1);
    sts.at_lt_nn   = at_r < nn;
    sts.hi_eq_at   = (nn - 1'b1) == at_r;
    sts.shift_last = sh_idx_r == at_r + 1'b1;
    sts.out_free   = !out_valid_r || out_tready;
  end

  always_comb begin
    ram_re    = cmd.sh_rd || cmd.rd_issue || scan_rd;
    ram_raddr = base_a + AW'(rd_idx_r);
    if (cmd.sh_rd) begin
      ram_raddr = base_a + AW'(sh_idx_r - 1'b1);
    end else if (cmd.rd_issue) begin
      ram_raddr = base_a + AW'(pos_r);
    end
    ram_we = cmd.sh_wr || cmd.ins_wr;
    if (cmd.sh_wr) begin
      ram_waddr = base_a + AW'(sh_idx_r);
      ram_wdata = ram_rdata;
    end else begin
      ram_waddr = base_a + AW'(at_r);
      ram_wdata = {score_r, tag_r};
    end
  end

  bstk_ram #(
    .WIDTH (bstk_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      larger_r <= bstk_pkg::LARGER_RST;
      limit_r  <= bstk_pkg::LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bstk_pkg::CFG_LARGER: larger_r <= cfg_data[0];
        bstk_pkg::CFG_LIMIT:  limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cmd.place && sel_ok) begin
      cnt_r[sel_ix] <= nn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        dv_r <= 1'b0;
      end else if (cmd.scan_step) begin
        dv_r <= scan_rd;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r   <= in_tuser[bstk_pkg::CMD_W-1:0];
      sel_r   <= in_tuser[bstk_pkg::IN_TUSER_W-1:bstk_pkg::CMD_W];
      score_r <= in_tdata[31:0];
      tag_r   <= in_tdata[47:32];
      pos_r   <= in_tdata[51:48];
      q_r     <= 1'b0;
      ev_r    <= 1'b0;
      es_r    <= '0;
      et_r    <= '0;
    end
    if (cmd.set_q) begin
      q_r <= 1'b1;
    end
    if (cmd.rd_cap) begin
      ev_r <= 1'b1;
      es_r <= ram_rdata[bstk_pkg::ENTRY_W-1:bstk_pkg::TAG_W];
      et_r <= ram_rdata[bstk_pkg::TAG_W-1:0];
    end
    if (cmd.scan_start) begin
      rd_idx_r <= '0;
    end else if (scan_rd) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
    if (cmd.scan_step) begin
      chk_r <= rd_idx_r;
    end
    if (cmd.at_hit) begin
      at_r <= chk_r;
    end else if (cmd.at_end) begin
      at_r <= n;
    end
    if (cmd.place) begin
      sh_idx_r <= nn - 1'b1;
    end else if (cmd.sh_wr) begin
      sh_idx_r <= sh_idx_r - 1'b1;
    end
    if (cmd.out_load) begin
      out_data_r <= {1'b0, bstk_pkg::CNT_OUT_W'(n), et_r, es_r, ev_r, q_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_IMP(a_ram_waddr_range, ram_we, 32'(ram_waddr) < DEPTH,
              "entry write outside RAM")
  `ASSERT_IMP(a_shift_above_at, cmd.sh_wr, sh_idx_r > at_r,
              "shift reached the insertion point")
  `ASSERT_IMP(a_out_no_overrun, cmd.out_load, !out_valid_r || out_tready,
              "result overwritten before taken")

endmodule

// File: rtl/core/bstk_ctrl.sv
// ----------------------------------------------------------------------------
// bstk_ctrl
// Command sequencer: evaluate, scan, shift and insert, read, deliver result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bstk_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  bstk_pkg::bstk_sts_t sts,
  output bstk_pkg::bstk_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVAL  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_PLACE = 4'd3;
  localparam logic [3:0] S_SHRD  = 4'd4;
  localparam logic [3:0] S_SHWR  = 4'd5;
  localparam logic [3:0] S_INSWR = 4'd6;
  localparam logic [3:0] S_RDW   = 4'd7;
  localparam logic [3:0] S_RES   = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       is_ask;

  assign in_tready = state_r == S_IDLE;
  assign is_ask    = sts.cmd == bstk_pkg::CMD_ASK;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_RES;
        if (sts.sel_ok) begin
          case (sts.cmd)
            bstk_pkg::CMD_ASK: begin
              if (sts.n_lt_lim) begin
                cmd.set_q = 1'b1;
              end else if (!sts.n_zero) begin
                cmd.scan_start = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
            bstk_pkg::CMD_INS: begin
              if (sts.n_zero) begin
                cmd.at_end = 1'b1;
                state_nxt  = S_PLACE;
              end else begin
                cmd.scan_start = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
            bstk_pkg::CMD_READ: begin
              if (sts.pos_lt_n) begin
                cmd.rd_issue = 1'b1;
                state_nxt    = S_RDW;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          if (is_ask) begin
            cmd.set_q = 1'b1;
            state_nxt = S_RES;
          end else begin
            cmd.at_hit = 1'b1;
            state_nxt  = S_PLACE;
          end
        end else if (sts.scan_last) begin
          if (is_ask) begin
            state_nxt = S_RES;
          end else begin
            cmd.at_end = 1'b1;
            state_nxt  = S_PLACE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        if (!sts.at_lt_nn) begin
          state_nxt = S_RES;
        end else if (sts.hi_eq_at) begin
          state_nxt = S_INSWR;
        end else begin
          state_nxt = S_SHRD;
        end
      end
      S_SHRD: begin
        cmd.sh_rd = 1'b1;
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = sts.shift_last ? S_INSWR : S_SHRD;
      end
      S_INSWR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = S_RES;
      end
      S_RDW: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = S_RES;
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_NXT(a_accept_to_eval, in_tvalid && in_tready, state_r == S_EVAL,
              "accepted request not evaluated")
  `ASSERT_NXT(a_result_held, state_r == S_RES && !sts.out_free, state_r == S_RES,
              "result dropped while output busy")

endmodule
